// ----- sv/wrg_pkg.sv -----
package wrg_pkg;

   localparam int GRID_CELLS    = 4096;
   localparam int ADDR_W        = $clog2(GRID_CELLS);
   localparam int CELL_W        = 16;
   localparam int SIDE_W        = 6;
   localparam int SIZE_W        = 7;
   localparam int DAMP_W        = 4;
   localparam int PHASE_W       = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 7;

   localparam logic [PHASE_W-1:0] DROP_INTERVAL   = 5'd24;
   localparam logic [CELL_W-1:0]  DROPLET_HEIGHT  = 16'd4000;
   localparam logic [CELL_W-1:0]  CELL_MAX        = 16'h7FFF;
   localparam logic [CELL_W-1:0]  CELL_MIN        = 16'h8000;
   localparam logic [16:0]        BRIGHT_LIMIT    = 17'd4095;
   localparam logic [15:0]        BRIGHT_SAT      = 16'hFFFF;
   localparam logic [SIZE_W-1:0]  SIDE_MAX        = 7'd64;
   localparam logic [DAMP_W-1:0]  DAMP_MIN        = 4'd1;
   localparam logic [DAMP_W-1:0]  DAMP_MAX        = 4'd8;
   localparam logic [DAMP_W-1:0]  DAMP_RESET      = 4'd4;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_STEP_INIT,
      ST_STEP_RUN,
      ST_STEP_DRAIN,
      ST_STEP_FINAL,
      ST_DROP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SIDE_W-1:0] pos_x;
      logic [SIDE_W-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [15:0] brightness;
      logic        any_energy;
   } rsp_type;

endpackage

// ----- sv/wrg_ram.sv -----
module wrg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata0 <= mem_ff[raddr0];
      rdata1 <= mem_ff[raddr1];
   end

endmodule

// ----- sv/water_ripple_grid_step.sv -----
// Step: each cell passes through one neighbor-sum and damping unit, and a droplet write
// follows when a droplet falls. Clear: zeroing sweep of all 4096 cells of both grids, then
// droplet and response. Read: registered memory read.
// One request at a time, the next taken once the response is registered; the
// response register lets the next request in while a response waits to be taken.
// Reset: synchronous; a zeroing sweep of all 4096 cells runs first with req_ready low, csr always taken.
module water_ripple_grid_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  wrg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output wrg_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wrg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wrg_pkg::CSR_DATA_W-1:0]  csr_data
);

   import wrg_pkg::*;

   state_type state_ff, state_in;

   logic [DAMP_W-1:0]  damp_ff;
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [DAMP_W-1:0]  d_c;
   logic [SIZE_W-1:0]  w_c, h_c;
   logic [SIDE_W-1:0]  w_m1, h_m1;

   logic [1:0]         op_ff, op_in;
   logic [SIDE_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               drop_flag_ff, drop_flag_in;
   logic               cur_b_ff, cur_b_in;
   logic [PHASE_W-1:0] phase_cnt_ff, phase_cnt_in;
   logic [PHASE_W-1:0] phase_next;
   logic [SIDE_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [SIDE_W-1:0]  xl, xr;
   logic [ADDR_W-1:0]  row_ff, row_in, up_row_ff, up_row_in, dn_row_ff, dn_row_in;
   logic               half_ff, half_in;
   logic               c_vld_ff, c_vld_in, d_vld_ff, d_vld_in;
   logic signed [16:0] ud_ff, ud_in;
   logic [CELL_W-1:0]  old_ff, old_in;
   logic [ADDR_W-1:0]  cidx_ff, cidx_in, didx_ff, didx_in;
   logic signed [17:0] v_ff, v_in;
   logic signed [17:0] sum18, half18, vsh;
   logic signed [18:0] damped;
   logic [CELL_W-1:0]  sat;
   logic               any_ff, any_in;
   logic [15:0]        bright_ff, bright_in;
   logic [16:0]        ext, mag;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [12:0]        dp_prod, up_prod;
   logic [ADDR_W-1:0]  dp_addr;
   logic               in_grid;

   logic [ADDR_W-1:0]  cur_ra0, cur_ra1, nxt_ra;
   logic [CELL_W-1:0]  a_rd0, a_rd1, b_rd0, b_rd1;
   logic [CELL_W-1:0]  cur_rd0, cur_rd1, nxt_rd0;
   logic               wr_en, wr_b, wr_both;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic               a_we, b_we;
   logic [ADDR_W-1:0]  a_ra0, b_ra0;

   assign d_c = (damp_ff < DAMP_MIN) ? DAMP_MIN : ((damp_ff > DAMP_MAX) ? DAMP_MAX : damp_ff);
   assign w_c = (width_ff == '0) ? SIZE_W'(1) : ((width_ff > SIDE_MAX) ? SIDE_MAX : width_ff);
   assign h_c = (height_ff == '0) ? SIZE_W'(1) : ((height_ff > SIDE_MAX) ? SIDE_MAX : height_ff);
   assign w_m1 = SIDE_W'(w_c - SIZE_W'(1));
   assign h_m1 = SIDE_W'(h_c - SIZE_W'(1));

   assign dp_prod = 13'(py_ff) * 13'(w_c);
   assign dp_addr = dp_prod[ADDR_W-1:0] + ADDR_W'(px_ff);
   assign in_grid = ({1'b0, px_ff} < w_c) && ({1'b0, py_ff} < h_c);
   assign up_prod = 13'(h_m1) * 13'(w_c);

   assign xl = (x_ff == '0) ? w_m1 : x_ff - SIDE_W'(1);
   assign xr = (x_ff == w_m1) ? '0 : x_ff + SIDE_W'(1);

   assign cur_rd0 = cur_b_ff ? b_rd0 : a_rd0;
   assign cur_rd1 = cur_b_ff ? b_rd1 : a_rd1;
   assign nxt_rd0 = cur_b_ff ? a_rd0 : b_rd0;
   assign a_ra0   = cur_b_ff ? nxt_ra : cur_ra0;
   assign b_ra0   = cur_b_ff ? cur_ra0 : nxt_ra;
   assign a_we    = wr_both || (wr_en && !wr_b);
   assign b_we    = wr_both || (wr_en && wr_b);

   assign sum18  = $signed({ud_ff[16], ud_ff}) + $signed({{2{cur_rd0[15]}}, cur_rd0})
                 + $signed({{2{cur_rd1[15]}}, cur_rd1});
   assign half18 = sum18 >>> 1;
   assign vsh    = v_ff >>> d_c;
   assign damped = $signed({v_ff[17], v_ff}) - $signed({vsh[17], vsh});
   assign sat    = (damped[18:15] == 4'b0000 || damped[18:15] == 4'b1111) ? damped[15:0]
                 : (damped[18] ? CELL_MIN : CELL_MAX);

   assign ext = {cur_rd0[15], cur_rd0};
   assign mag = ext[16] ? (~ext + 17'd1) : ext;

   assign phase_next = phase_cnt_ff + PHASE_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wrg_ram #(.WIDTH(CELL_W), .DEPTH(GRID_CELLS)) u_grid_a (
      .clock  (clock),
      .we     (a_we),
      .waddr  (wr_addr),
      .wdata  (wr_data),
      .raddr0 (a_ra0),
      .raddr1 (cur_ra1),
      .rdata0 (a_rd0),
      .rdata1 (a_rd1)
   );

   wrg_ram #(.WIDTH(CELL_W), .DEPTH(GRID_CELLS)) u_grid_b (
      .clock  (clock),
      .we     (b_we),
      .waddr  (wr_addr),
      .wdata  (wr_data),
      .raddr0 (b_ra0),
      .raddr1 (cur_ra1),
      .rdata0 (b_rd0),
      .rdata1 (b_rd1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      clr_addr_in  = clr_addr_ff;
      drop_flag_in = drop_flag_ff;
      cur_b_in     = cur_b_ff;
      phase_cnt_in = phase_cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      row_in       = row_ff;
      up_row_in    = up_row_ff;
      dn_row_in    = dn_row_ff;
      half_in      = half_ff;
      ud_in        = ud_ff;
      old_in       = old_ff;
      cidx_in      = cidx_ff;
      didx_in      = didx_ff;
      v_in         = v_ff;
      any_in       = any_ff;
      bright_in    = bright_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      c_vld_in     = 1'b0;
      d_vld_in     = c_vld_ff;
      cur_ra0      = row_ff + ADDR_W'(xl);
      cur_ra1      = row_ff + ADDR_W'(xr);
      nxt_ra       = row_ff + ADDR_W'(x_ff);
      wr_en        = 1'b0;
      wr_b         = !cur_b_ff;
      wr_both      = 1'b0;
      wr_addr      = didx_ff;
      wr_data      = sat;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // neighbor sum, damping and write-back of cells in flight
      if (c_vld_ff) begin
         v_in    = half18 - $signed({{2{old_ff[15]}}, old_ff});
         didx_in = cidx_ff;
      end
      if (d_vld_ff) begin
         wr_en = 1'b1;
         if (sat != '0) begin
            any_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_both     = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               state_in = drop_flag_ff ? ST_DROP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_data.op;
               px_in = req_data.pos_x;
               py_in = req_data.pos_y;
               unique case (req_data.op)
                  OP_CLEAR: begin
                     drop_flag_in = 1'b1;
                     phase_cnt_in = '0;
                     clr_addr_in  = '0;
                     state_in     = ST_CLEAR;
                  end
                  OP_STEP:  state_in = ST_STEP_INIT;
                  OP_READ:  state_in = ST_RD_ISSUE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_ISSUE: begin
            cur_ra0  = dp_addr;
            state_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            if (!in_grid) begin
               bright_in = '0;
            end else if (mag > BRIGHT_LIMIT) begin
               bright_in = BRIGHT_SAT;
            end else begin
               bright_in = {mag[11:0], 4'b0000};
            end
            state_in = ST_DONE;
         end
         ST_STEP_INIT: begin
            x_in      = '0;
            y_in      = '0;
            row_in    = '0;
            up_row_in = up_prod[ADDR_W-1:0];
            dn_row_in = (h_m1 == '0) ? '0 : ADDR_W'(w_c);
            half_in   = 1'b0;
            any_in    = 1'b0;
            state_in  = ST_STEP_RUN;
         end
         ST_STEP_RUN: begin
            half_in = !half_ff;
            if (!half_ff) begin
               cur_ra0 = up_row_ff + ADDR_W'(x_ff);
               cur_ra1 = dn_row_ff + ADDR_W'(x_ff);
            end else begin
               ud_in    = $signed({cur_rd0[15], cur_rd0}) + $signed({cur_rd1[15], cur_rd1});
               old_in   = nxt_rd0;
               cidx_in  = row_ff + ADDR_W'(x_ff);
               c_vld_in = 1'b1;
               if (x_ff == w_m1) begin
                  x_in = '0;
                  if (y_ff == h_m1) begin
                     state_in = ST_STEP_DRAIN;
                  end else begin
                     y_in      = y_ff + SIDE_W'(1);
                     up_row_in = row_ff;
                     row_in    = dn_row_ff;
                     dn_row_in = (y_ff + SIDE_W'(1) == h_m1) ? '0 : dn_row_ff + ADDR_W'(w_c);
                  end
               end else begin
                  x_in = x_ff + SIDE_W'(1);
               end
            end
         end
         ST_STEP_DRAIN: begin
            if (!c_vld_ff && !d_vld_ff) begin
               state_in = ST_STEP_FINAL;
            end
         end
         ST_STEP_FINAL: begin
            cur_b_in = !cur_b_ff;
            if (phase_next >= DROP_INTERVAL) begin
               phase_cnt_in = '0;
               drop_flag_in = 1'b1;
               state_in     = ST_DROP;
            end else begin
               phase_cnt_in = phase_next;
               state_in     = ST_DONE;
            end
         end
         ST_DROP: begin
            drop_flag_in = 1'b0;
            if (in_grid) begin
               wr_en   = 1'b1;
               wr_b    = cur_b_ff;
               wr_addr = dp_addr;
               wr_data = DROPLET_HEIGHT;
               any_in  = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            drop_flag_in = 1'b0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.brightness = (op_ff == OP_READ) ? bright_ff : '0;
               rsp_in.any_energy = (op_ff == OP_STEP) && any_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff      <= DAMP_RESET;
         width_ff     <= SIDE_MAX;
         height_ff    <= SIDE_MAX;
         clr_addr_ff  <= '0;
         drop_flag_ff <= 1'b0;
         cur_b_ff     <= 1'b0;
         phase_cnt_ff <= '0;
         half_ff      <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DAMPING_SHIFT: damp_ff   <= csr_data[DAMP_W-1:0];
               CSR_GRID_WIDTH:    width_ff  <= csr_data;
               CSR_GRID_HEIGHT:   height_ff <= csr_data;
               default: ;
            endcase
         end
         clr_addr_ff  <= clr_addr_in;
         drop_flag_ff <= drop_flag_in;
         cur_b_ff     <= cur_b_in;
         phase_cnt_ff <= phase_cnt_in;
         half_ff      <= half_in;
         c_vld_ff     <= c_vld_in;
         d_vld_ff     <= d_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      row_ff    <= row_in;
      up_row_ff <= up_row_in;
      dn_row_ff <= dn_row_in;
      ud_ff     <= ud_in;
      old_ff    <= old_in;
      cidx_ff   <= cidx_in;
      didx_ff   <= didx_in;
      v_ff      <= v_in;
      any_ff    <= any_in;
      bright_ff <= bright_in;
      rsp_ff    <= rsp_in;
   end

endmodule
